[design/trp_pkg.sv]
package trp_pkg;

    localparam int TEXEL_W = 16;
    localparam int CHAN_W  = 8;
    localparam int GEOM_W  = 4;
    localparam int INDEX_W = 3;

    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_ARGB4444 = 2'd1,
        FMT_ARGB1555 = 2'd2
    } src_format_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_SOURCE_FORMAT = 3'd0,
        REG_RED_MASK      = 3'd1,
        REG_GREEN_MASK    = 3'd2,
        REG_BLUE_MASK     = 3'd3,
        REG_ALPHA_MASK    = 3'd4
    } reg_index_t;

    // Position (lowest set bit) and width (length of the run there, capped at 8)
    typedef struct packed {
        logic [GEOM_W-1:0] pos;
        logic [GEOM_W-1:0] width;
    } chan_geom_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } chan_set_t;

    localparam chan_geom_t GEOM_RED_RST   = '{pos: 4'd11, width: 4'd5};
    localparam chan_geom_t GEOM_GREEN_RST = '{pos: 4'd5,  width: 4'd6};
    localparam chan_geom_t GEOM_BLUE_RST  = '{pos: 4'd0,  width: 4'd5};
    localparam chan_geom_t GEOM_ALPHA_RST = '{pos: 4'd0,  width: 4'd0};

    // A zero mask yields width 0, which shifts the whole channel out
    function automatic chan_geom_t decode_mask(input logic [TEXEL_W-1:0] mask);
        chan_geom_t         geom;
        logic [TEXEL_W-1:0] run;
        logic               stop;
        geom.pos   = '0;
        geom.width = '0;
        stop       = 1'b0;
        for (int i = TEXEL_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                geom.pos = GEOM_W'(i);
            end
        end
        run = mask >> geom.pos;
        for (int i = 0; i < CHAN_W; i++)
        begin
            if (!stop && run[i])
            begin
                geom.width = geom.width + GEOM_W'(1);
            end
            else
            begin
                stop = 1'b1;
            end
        end
        return geom;
    endfunction

endpackage

[design/trp_channels.sv]
interface trp_src_if
    import trp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] source_texel;

    modport source (output valid, output source_texel, input ready);
    modport sink   (input valid, input source_texel, output ready);
endinterface

interface trp_dst_if
    import trp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] packed_texel;

    modport source (output valid, output packed_texel, input ready);
    modport sink   (input valid, input packed_texel, output ready);
endinterface

[design/trp_place_lane.sv]
module trp_place_lane
    import trp_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [CHAN_W-1:0]  chan,
    input  chan_geom_t         geom,
    output logic [TEXEL_W-1:0] placed
);

    logic [CHAN_W-1:0]  shifted_reg;
    logic [CHAN_W-1:0]  shifted_next;
    logic [GEOM_W-1:0]  shr;
    logic [TEXEL_W-1:0] wide;

    // drop the low bits that the destination field cannot hold
    assign shr          = GEOM_W'(CHAN_W) - geom.width;
    assign shifted_next = chan >> shr;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shifted_reg <= shifted_next;
        end
    end

    // move into place; bits pushed past the top are lost
    assign wide   = {{(TEXEL_W - CHAN_W){1'b0}}, shifted_reg};
    assign placed = wide << geom.pos;

endmodule

[design/texel_format_repacker_core.sv]
// Channel     | Dir | Handshake     | Payload
// ------------+-----+---------------+------------------------------------
// texel_in    | in  | valid / ready | source_texel [15:0]
// texel_out   | out | valid / ready | packed_texel [15:0]
// cfg_*       | in  | cfg_we only   | cfg_index [2:0], cfg_data [15:0]
//
// One item per cycle sustained while texel_out is ready; each item passes in turn
// through the input register, channel unpack, right shift, and place and merge.
// Reset clears the stage valid bits and loads the default RGB565 layout.
// Each stage holds while the one after it is full and stalled, so a stall at
// the output reaches back through the full stages combinationally and no item is dropped or repeated.
module texel_format_repacker_core
    import trp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [TEXEL_W-1:0]  cfg_data,
    trp_src_if.sink             texel_in,
    trp_dst_if.source           texel_out
);

    // Configuration: masks are decoded to position/width as they are written
    src_format_t fmt_reg;
    chan_geom_t  geom_red_reg;
    chan_geom_t  geom_green_reg;
    chan_geom_t  geom_blue_reg;
    chan_geom_t  geom_alpha_reg;
    chan_geom_t  geom_wr;

    assign geom_wr = decode_mask(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= FMT_RGB565;
            geom_red_reg   <= GEOM_RED_RST;
            geom_green_reg <= GEOM_GREEN_RST;
            geom_blue_reg  <= GEOM_BLUE_RST;
            geom_alpha_reg <= GEOM_ALPHA_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SOURCE_FORMAT: fmt_reg        <= src_format_t'(cfg_data[1:0]);
                REG_RED_MASK:      geom_red_reg   <= geom_wr;
                REG_GREEN_MASK:    geom_green_reg <= geom_wr;
                REG_BLUE_MASK:     geom_blue_reg  <= geom_wr;
                REG_ALPHA_MASK:    geom_alpha_reg <= geom_wr;
                default:           ;
            endcase
        end
    end

    // Stage valid bits and the ready chain running back from the output
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || texel_out.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign texel_in.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= texel_in.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: capture the incoming item
    logic [TEXEL_W-1:0] texel1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && texel_in.valid)
        begin
            texel1_reg <= texel_in.source_texel;
        end
    end

    // Stage 2: split into four 8-bit channels, left-shifted; 1-bit alpha copied, no alpha: all ones
    chan_set_t chan2_reg;
    chan_set_t chan2_next;

    always_comb
    begin
        unique case (fmt_reg)
            FMT_ARGB4444:
            begin
                chan2_next.blue  = {texel1_reg[3:0],   4'h0};
                chan2_next.green = {texel1_reg[7:4],   4'h0};
                chan2_next.red   = {texel1_reg[11:8],  4'h0};
                chan2_next.alpha = {texel1_reg[15:12], 4'h0};
            end
            FMT_ARGB1555:
            begin
                chan2_next.blue  = {texel1_reg[4:0],   3'h0};
                chan2_next.green = {texel1_reg[9:5],   3'h0};
                chan2_next.red   = {texel1_reg[14:10], 3'h0};
                chan2_next.alpha = {CHAN_W{texel1_reg[15]}};
            end
            // RGB565, and the unused code, which decodes the same way
            default:
            begin
                chan2_next.blue  = {texel1_reg[4:0],   3'h0};
                chan2_next.green = {texel1_reg[10:5],  2'h0};
                chan2_next.red   = {texel1_reg[15:11], 3'h0};
                chan2_next.alpha = {CHAN_W{1'b1}};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            chan2_reg <= chan2_next;
        end
    end

    // Stage 3: each lane cuts its channel to the field width and holds it,
    // then shifts it to the field position on the way to stage 4
    logic               load3;
    logic [TEXEL_W-1:0] placed_red;
    logic [TEXEL_W-1:0] placed_green;
    logic [TEXEL_W-1:0] placed_blue;
    logic [TEXEL_W-1:0] placed_alpha;

    assign load3 = rdy3 && v2_reg;

    trp_place_lane u_lane_red (
        .clk    (clk),
        .load   (load3),
        .chan   (chan2_reg.red),
        .geom   (geom_red_reg),
        .placed (placed_red)
    );

    trp_place_lane u_lane_green (
        .clk    (clk),
        .load   (load3),
        .chan   (chan2_reg.green),
        .geom   (geom_green_reg),
        .placed (placed_green)
    );

    trp_place_lane u_lane_blue (
        .clk    (clk),
        .load   (load3),
        .chan   (chan2_reg.blue),
        .geom   (geom_blue_reg),
        .placed (placed_blue)
    );

    trp_place_lane u_lane_alpha (
        .clk    (clk),
        .load   (load3),
        .chan   (chan2_reg.alpha),
        .geom   (geom_alpha_reg),
        .placed (placed_alpha)
    );

    // Stage 4: merge the lanes into the output register; overlapping
    // fields simply OR together
    logic [TEXEL_W-1:0] packed4_reg;
    logic [TEXEL_W-1:0] packed4_next;

    assign packed4_next = placed_red | placed_green | placed_blue | placed_alpha;

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            packed4_reg <= packed4_next;
        end
    end

    assign texel_out.valid        = v4_reg;
    assign texel_out.packed_texel = packed4_reg;

endmodule

[design/trp_checker.sv]
module trp_checker
    import trp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [TEXEL_W-1:0] packed_texel
);

    // hold a stalled result steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_texel))
        else $error("stalled result changed or vanished");

    // an empty output stage means the whole pipe can take an item
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with an empty output stage");

    // with the output drained while it moves through, an accepted item reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("item did not reach the output in time");

endmodule

bind texel_format_repacker_core trp_checker u_trp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (texel_in.valid),
    .in_ready     (texel_in.ready),
    .out_valid    (texel_out.valid),
    .out_ready    (texel_out.ready),
    .packed_texel (texel_out.packed_texel)
);

[bench/tb_texel_format_repacker_core.sv]
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the layout registers, works out the
// packed texel for every accepted source texel and compares results in order.
class texel_scoreboard;

    logic [1:0]                     src_fmt;
    logic [trp_pkg::TEXEL_W-1:0]    red_mask;
    logic [trp_pkg::TEXEL_W-1:0]    green_mask;
    logic [trp_pkg::TEXEL_W-1:0]    blue_mask;
    logic [trp_pkg::TEXEL_W-1:0]    alpha_mask;
    logic [trp_pkg::TEXEL_W-1:0]    expected_texels[$];
    int                             mismatches;

    function new();
        src_fmt    = trp_pkg::FMT_RGB565;
        red_mask   = 16'hF800;
        green_mask = 16'h07E0;
        blue_mask  = 16'h001F;
        alpha_mask = 16'h0000;
        mismatches = 0;
    endfunction

    function void set_reg(trp_pkg::reg_index_t idx, logic [trp_pkg::TEXEL_W-1:0] value);
        case (idx)
            trp_pkg::REG_SOURCE_FORMAT: src_fmt    = value[1:0];
            trp_pkg::REG_RED_MASK:      red_mask   = value;
            trp_pkg::REG_GREEN_MASK:    green_mask = value;
            trp_pkg::REG_BLUE_MASK:     blue_mask  = value;
            trp_pkg::REG_ALPHA_MASK:    alpha_mask = value;
            default:                    ;
        endcase
    endfunction

    // Lowest run of ones sets the position; its length, capped at 8, the width
    function logic [15:0] place_level(logic [7:0] level, logic [15:0] mask);
        int          lsb;
        int          run;
        logic [31:0] wide;
        if (mask == 16'h0000)
            return 16'h0000;
        lsb = 0;
        while (!mask[lsb])
            lsb++;
        run = 0;
        while ((lsb + run) < 16 && run < 8 && mask[lsb + run])
            run++;
        wide = (32'(level) >> (8 - run)) << lsb;
        return wide[15:0];
    endfunction

    function logic [15:0] pack_texel(logic [15:0] t);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        case (src_fmt)
            trp_pkg::FMT_ARGB4444:
            begin
                b = {t[3:0], 4'h0};
                g = {t[7:4], 4'h0};
                r = {t[11:8], 4'h0};
                a = {t[15:12], 4'h0};
            end
            trp_pkg::FMT_ARGB1555:
            begin
                b = {t[4:0], 3'b000};
                g = {t[9:5], 3'b000};
                r = {t[14:10], 3'b000};
                a = t[15] ? 8'hFF : 8'h00;
            end
            default:
            begin
                b = {t[4:0], 3'b000};
                g = {t[10:5], 2'b00};
                r = {t[15:11], 3'b000};
                a = 8'hFF;
            end
        endcase
        return place_level(b, blue_mask) | place_level(g, green_mask)
             | place_level(r, red_mask)  | place_level(a, alpha_mask);
    endfunction

    function void note_texel(logic [15:0] t);
        expected_texels.push_back(pack_texel(t));
    endfunction

    function void check_texel(logic [15:0] actual);
        logic [15:0] want;
        if (expected_texels.size() == 0)
        begin
            $error("packed_texel: expected nothing, got 0x%04h", actual);
            mismatches++;
            return;
        end
        want = expected_texels.pop_front();
        if (actual !== want)
        begin
            $error("packed_texel: expected 0x%04h, got 0x%04h", want, actual);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_texels.size();
    endfunction

endclass

module tb_texel_format_repacker_core;
    import trp_pkg::*;

    // Four pipe stages; the depth sets the settling wait after each drain and
    // the end hold before the run is called complete
    localparam int PIPE_DEPTH    = 4;
    localparam int END_HOLD      = 4 * PIPE_DEPTH;
    // Cycles with no item moved and no register write before giving up
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 50;
    // Format code with no layout of its own; decodes as RGB565
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [INDEX_W-1:0] cfg_index;
    logic [TEXEL_W-1:0] cfg_data;

    trp_src_if texel_in_if ();
    trp_dst_if texel_out_if ();

    texel_scoreboard sb;

    int burst_left;
    int idle_cycles = 0;

    texel_format_repacker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .texel_in  (texel_in_if),
        .texel_out (texel_out_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drop valid, with random data on the bus, for an idle gap of the given length
    task automatic idle_input(input int n);
        @(negedge clk);
        texel_in_if.valid        <= 1'b0;
        texel_in_if.source_texel <= 16'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one texel and hold it until the block takes it. The sender runs
    // in bursts: when a burst is used up, pause for a random gap (often none)
    // and pick a fresh burst length.
    task automatic send_texel(input logic [TEXEL_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
                idle_input(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        texel_in_if.valid        <= 1'b1;
        texel_in_if.source_texel <= t;
        do
            @(posedge clk);
        while (!texel_in_if.ready);
        sb.note_texel(t);
    endtask

    // Stop offering items and wait until every packed texel has come back,
    // then let the pipe settle so nothing is still in flight
    task automatic drain_results();
        @(negedge clk);
        texel_in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Layout registers
    // ------------------------------------------------------------------

    task automatic write_reg(input reg_index_t idx, input logic [TEXEL_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
    endtask

    // Write every register back to back; only called with the pipe empty
    task automatic apply_layout(input logic [TEXEL_W-1:0] fmt_word,
                                input logic [TEXEL_W-1:0] r,
                                input logic [TEXEL_W-1:0] g,
                                input logic [TEXEL_W-1:0] b,
                                input logic [TEXEL_W-1:0] a);
        drain_results();
        write_reg(REG_SOURCE_FORMAT, fmt_word);
        write_reg(REG_RED_MASK, r);
        write_reg(REG_GREEN_MASK, g);
        write_reg(REG_BLUE_MASK, b);
        write_reg(REG_ALPHA_MASK, a);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mix of mask shapes: mostly clean runs of ones, some arbitrary bit
    // patterns (gaps, several runs), the odd empty or full mask
    function automatic logic [TEXEL_W-1:0] pick_mask();
        int          lsb;
        int          len;
        logic [31:0] run;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom);
            default:
            begin
                lsb = $urandom_range(0, 15);
                len = $urandom_range(1, 12);
                run = ((32'd1 << len) - 32'd1) << lsb;
                return run[15:0];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Ready follows a pattern of its own: stretches always ready, coin-flip
    // stalls, periodic stalls and rare stalls, each for a random stretch
    initial
    begin : ready_pattern
        int mode;
        int len;
        int period;
        texel_out_if.ready = 1'b0;
        forever
        begin
            mode   = $urandom_range(0, 3);
            len    = $urandom_range(16, 96);
            period = $urandom_range(2, 6);
            for (int i = 0; i < len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       texel_out_if.ready <= 1'b1;
                    1:       texel_out_if.ready <= 1'($urandom_range(0, 1));
                    2:       texel_out_if.ready <= ((i % period) != 0);
                    default: texel_out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Check each packed texel as it is taken
    always @(posedge clk)
    begin
        if (rst_n && texel_out_if.valid && texel_out_if.ready)
            sb.check_texel(texel_out_if.packed_texel);
    end

    // Watchdog: count cycles in which nothing moves on either channel and no
    // register is written
    always @(posedge clk)
    begin
        if ((texel_in_if.valid && texel_in_if.ready)
            || (texel_out_if.valid && texel_out_if.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        logic [1:0]  fmt;
        logic [13:0] junk;

        sb                        = new();
        burst_left                = 0;
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        texel_in_if.valid         = 1'b0;
        texel_in_if.source_texel  = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset layout: RGB565 into RGB565, no alpha
        send_texel(16'h0000);
        send_texel(16'hFFFF);
        send_texel(16'hF800);
        send_texel(16'h07E0);
        send_texel(16'h001F);
        send_texel(16'hA5A5);

        // ARGB4444 into its own layout
        apply_layout({14'h0, FMT_ARGB4444}, 16'h0F00, 16'h00F0, 16'h000F, 16'hF000);
        send_texel(16'h0000);
        send_texel(16'hFFFF);
        send_texel(16'h1234);
        send_texel(16'hF000);

        // ARGB1555: alpha bit set and clear
        apply_layout({14'h0, FMT_ARGB1555}, 16'h7C00, 16'h03E0, 16'h001F, 16'h8000);
        send_texel(16'h8000);
        send_texel(16'h7FFF);
        send_texel(16'h0000);
        send_texel(16'hFFFF);

        // Unused format code; wide red mask overlapping the others, green
        // mask with a gap, blue at the very top bit, alpha dropped
        apply_layout({14'h0, FMT_UNUSED}, 16'hFFFF, 16'h0F0F, 16'h8000, 16'h0000);
        send_texel(16'hFFFF);
        send_texel(16'h5555);
        send_texel(16'hAAAA);

        // Every channel dropped
        apply_layout({14'h0, FMT_RGB565}, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_texel(16'hFFFF);

        // Every channel across the whole word
        apply_layout({14'h0, FMT_ARGB1555}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_texel(16'h8000);
        send_texel(16'h0001);

        // Random layouts, random texels; junk in the unused upper bits of the
        // format write. Now and then hold the sender until all has drained.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            fmt  = 2'($urandom_range(0, 3));
            junk = 14'($urandom);
            apply_layout({junk, fmt}, pick_mask(), pick_mask(), pick_mask(), pick_mask());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && (p % 3) == 0)
                    drain_results();
                send_texel(16'($urandom));
            end
        end

        drain_results();
        repeat (END_HOLD) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
